/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LVH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lvh assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LVH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lvh assertion failed");

`endif

/* src/lvh_pkg.sv */
// Package for the two-level hash table: defaults, command and status codes.
package lvh_pkg;

  localparam int LVH_TOP_BUCKETS_LOG2 = 10;
  localparam int LVH_SLOTS_PER_BUCKET = 4;
  localparam int LVH_KEY_BITS         = 64;
  localparam int LVH_VALUE_BITS       = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

/* src/lvh_row_mem.sv */
// Bucket-row memory: one write port, one read port with registered read data.
module lvh_row_mem
  import lvh_pkg::*;
#(
  parameter int ADDR_BITS = LVH_TOP_BUCKETS_LOG2,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/two_level_cuckoo_hash_table.sv */
// Top level of the two-level hash table with its command sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries a command (insert,
//   query, delete, update), a key, a value and the key's two hashes. A beat is
//   taken when in_valid is high and in_stall is low. The block works on one
//   beat at a time; in_stall stays high from acceptance until the result beat
//   has been taken.
//   Result channel (out_valid / out_stall): exactly one beat per command, with
//   status (0 ok, 1 not found or table full) and read_value (query data, else
//   zero). While out_stall is high the result holds and no new input is taken.
//   Configuration: cfg_wr_en writes cfg_wr_data into the bottom-to-top enable.
// Steps from acceptance to result valid:
//   query/delete/update: the 4 buckets are read in two pairs (both first buckets,
//   then both second buckets), then compared one bucket per cycle.
//   insert: a free slot is sought in the top bucket pair, then in the bottom pair;
//   failing that, residents are moved within their level (up to 4*SLOTS_PER_BUCKET
//   residents tried), and then, if enabled, bottom residents are moved up.
//   Each level memory has a single read port, so its bucket reads go one by one.
// Reset: a clearing pass writes every bucket row empty, with in_stall high;
//   configuration writes are taken throughout.
module two_level_cuckoo_hash_table
  import lvh_pkg::*;
#(
  parameter int TOP_BUCKETS_LOG2 = LVH_TOP_BUCKETS_LOG2,
  parameter int SLOTS_PER_BUCKET = LVH_SLOTS_PER_BUCKET,
  parameter int KEY_BITS         = LVH_KEY_BITS,
  parameter int VALUE_BITS       = LVH_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic [63:0] in_data_value,
  input  logic [31:0] in_first_hash,
  input  logic [31:0] in_second_hash,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [63:0] out_read_value,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int L  = TOP_BUCKETS_LOG2;
  localparam int S  = SLOTS_PER_BUCKET;
  localparam int HK = L - 1;                 // kept bits of each hash
  localparam int IW = (S > 1) ? $clog2(S) : 1;

  // One bucket: all slots side by side, read and written as a whole row.
  typedef struct packed {
    logic [S-1:0]                 valid;
    logic [S-1:0][KEY_BITS-1:0]   key;
    logic [S-1:0][VALUE_BITS-1:0] val;
    logic [S-1:0][2*HK-1:0]       hash;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_F, S_RD_S, S_RD_W, S_FIND, S_FREE,
    S_MV_RD, S_MV_CHK, S_MV_WB, S_UP_RDF, S_UP_RDS, S_UP_CHK, S_UP_WB, S_RESULT
  } state_t;

  state_t                state_r;
  logic [L-1:0]          clr_r;
  logic [1:0]            k_r;     // candidate bucket: top first/second, bottom first/second
  logic [IW-1:0]         i_r;     // resident slot being moved
  logic                  enable_r;
  cmd_t                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HK-1:0]         fh_r;
  logic [HK-1:0]         sh_r;
  row_t                  rows_r [4];
  row_t                  upf_r;
  logic                  out_valid_r;
  logic                  status_r;
  logic [63:0]           rv_r;

  logic [ROW_W-1:0] top_rdata, bot_rdata;
  row_t             rd_top, rd_bot;
  logic [L-1:0]     top_raddr, top_waddr;
  logic [L-2:0]     bot_raddr, bot_waddr;
  logic             top_we, bot_we;
  logic [ROW_W-1:0] top_wdata, bot_wdata;

  logic [L-1:0]  addr_k [4];
  row_t          cur_row;
  logic [2*HK-1:0] new_hash, res_hash;
  logic [L-1:0]  rf_t, rs_t, rf_b, rs_b, rf, rs, alt_addr;

  logic          match_any;
  logic [IW-1:0] match_j;
  row_t          pa, pb, arow;
  logic          pf, psel, af;
  logic [IW-1:0] pj, aj;

  logic          wr_en, wr_lvl;
  logic [L-1:0]  wr_addr;
  row_t          wr_row;

  assign rd_top = row_t'(top_rdata);
  assign rd_bot = row_t'(bot_rdata);

  // Candidate bucket addresses, all carried at the top level's width.
  assign addr_k[0] = {1'b0, fh_r};
  assign addr_k[1] = {1'b1, sh_r};
  assign addr_k[2] = {2'b00, fh_r[HK-2:0]};
  assign addr_k[3] = {2'b01, sh_r[HK-2:0]};
  assign new_hash  = {sh_r, fh_r};

  // Resident under consideration and its buckets in either level.
  assign cur_row  = rows_r[k_r];
  assign res_hash = cur_row.hash[i_r];
  assign rf_t     = {1'b0, res_hash[HK-1:0]};
  assign rs_t     = {1'b1, res_hash[2*HK-1:HK]};
  assign rf_b     = {2'b00, res_hash[HK-2:0]};
  assign rs_b     = {2'b01, res_hash[HK+HK-2:HK]};
  assign rf       = k_r[1] ? rf_b : rf_t;
  assign rs       = k_r[1] ? rs_b : rs_t;
  assign alt_addr = (rf == addr_k[k_r]) ? rs : rf;

  // Key compare over one bucket; lowest matching slot wins.
  always_comb begin
    match_any = 1'b0;
    match_j   = '0;
    for (int j = S - 1; j >= 0; j--) begin
      if (cur_row.valid[j] && cur_row.key[j] == key_r) begin
        match_any = 1'b1;
        match_j   = IW'(j);
      end
    end
  end

  // Free-slot search over a bucket pair: slot j of the first before slot j of the second.
  always_comb begin
    pa   = (state_r == S_UP_CHK) ? upf_r  : rows_r[k_r];
    pb   = (state_r == S_UP_CHK) ? rd_top : rows_r[{k_r[1], 1'b1}];
    pf   = 1'b0;
    psel = 1'b0;
    pj   = '0;
    for (int j = S - 1; j >= 0; j--) begin
      if (!pb.valid[j]) begin
        pf = 1'b1; psel = 1'b1; pj = IW'(j);
      end
      if (!pa.valid[j]) begin
        pf = 1'b1; psel = 1'b0; pj = IW'(j);
      end
    end
  end

  // Free-slot search in the alternate bucket just read.
  always_comb begin
    arow = k_r[1] ? rd_bot : rd_top;
    af   = 1'b0;
    aj   = '0;
    for (int j = S - 1; j >= 0; j--) begin
      if (!arow.valid[j]) begin
        af = 1'b1; aj = IW'(j);
      end
    end
  end

  // Row write request for the current step.
  always_comb begin
    wr_en   = 1'b0;
    wr_lvl  = k_r[1];
    wr_addr = addr_k[k_r];
    wr_row  = cur_row;
    case (state_r)
      S_FIND: begin
        if (match_any && cmd_r != CMD_QUERY) begin
          wr_en = 1'b1;
          if (cmd_r == CMD_DELETE) begin
            wr_row.valid[match_j] = 1'b0;
          end else begin
            wr_row.val[match_j] = val_r;
          end
        end
      end
      S_FREE: begin
        wr_en   = pf;
        wr_addr = psel ? addr_k[{k_r[1], 1'b1}] : addr_k[k_r];
        wr_row  = psel ? pb : pa;
        wr_row.valid[pj] = 1'b1;
        wr_row.key[pj]   = key_r;
        wr_row.val[pj]   = val_r;
        wr_row.hash[pj]  = new_hash;
      end
      S_MV_CHK: begin
        wr_en   = af;
        wr_addr = alt_addr;
        wr_row  = arow;
        wr_row.valid[aj] = 1'b1;
        wr_row.key[aj]   = cur_row.key[i_r];
        wr_row.val[aj]   = cur_row.val[i_r];
        wr_row.hash[aj]  = res_hash;
      end
      S_UP_CHK: begin
        wr_en   = pf;
        wr_lvl  = 1'b0;
        wr_addr = psel ? rs_t : rf_t;
        wr_row  = psel ? pb : pa;
        wr_row.valid[pj] = 1'b1;
        wr_row.key[pj]   = cur_row.key[i_r];
        wr_row.val[pj]   = cur_row.val[i_r];
        wr_row.hash[pj]  = res_hash;
      end
      S_MV_WB, S_UP_WB: begin
        // New item takes the slot its resident left.
        wr_en = 1'b1;
        wr_row.valid[i_r] = 1'b1;
        wr_row.key[i_r]   = key_r;
        wr_row.val[i_r]   = val_r;
        wr_row.hash[i_r]  = new_hash;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Route the request to the level memories; the clearing pass writes both.
  always_comb begin
    if (state_r == S_CLEAR) begin
      top_we    = 1'b1;
      bot_we    = 1'b1;
      top_waddr = clr_r;
      bot_waddr = clr_r[L-2:0];
      top_wdata = '0;
      bot_wdata = '0;
    end else begin
      top_we    = wr_en && !wr_lvl;
      bot_we    = wr_en && wr_lvl;
      top_waddr = wr_addr;
      bot_waddr = wr_addr[L-2:0];
      top_wdata = wr_row;
      bot_wdata = wr_row;
    end
  end

  // Read addresses: data shows up in rd_top / rd_bot in the next cycle.
  always_comb begin
    top_raddr = addr_k[0];
    bot_raddr = addr_k[2][L-2:0];
    case (state_r)
      S_RD_S: begin
        top_raddr = addr_k[1];
        bot_raddr = addr_k[3][L-2:0];
      end
      S_MV_RD: begin
        top_raddr = alt_addr;
        bot_raddr = alt_addr[L-2:0];
      end
      S_UP_RDF: top_raddr = rf_t;
      S_UP_RDS: top_raddr = rs_t;
      default:  top_raddr = addr_k[0];
    endcase
  end

  lvh_row_mem #(.ADDR_BITS(L), .DATA_BITS(ROW_W)) u_top_mem (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .raddr (top_raddr),
    .rdata (top_rdata)
  );

  lvh_row_mem #(.ADDR_BITS(L - 1), .DATA_BITS(ROW_W)) u_bot_mem (
    .clk   (clk),
    .we    (bot_we),
    .waddr (bot_waddr),
    .wdata (bot_wdata),
    .raddr (bot_raddr),
    .rdata (bot_rdata)
  );

  // Sequencer: state, counters, latched command and result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      k_r         <= '0;
      i_r         <= '0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_command);
            key_r   <= in_key[KEY_BITS-1:0];
            val_r   <= in_data_value[VALUE_BITS-1:0];
            fh_r    <= in_first_hash[HK-1:0];
            sh_r    <= in_second_hash[HK-1:0];
            state_r <= S_RD_F;
          end
        end
        S_RD_F: state_r <= S_RD_S;
        S_RD_S: begin
          rows_r[0] <= rd_top;
          rows_r[2] <= rd_bot;
          state_r   <= S_RD_W;
        end
        S_RD_W: begin
          rows_r[1] <= rd_top;
          rows_r[3] <= rd_bot;
          k_r       <= '0;
          i_r       <= '0;
          state_r   <= (cmd_r == CMD_INSERT) ? S_FREE : S_FIND;
        end
        S_FIND: begin
          if (match_any) begin
            status_r    <= STATUS_OK;
            rv_r        <= (cmd_r == CMD_QUERY) ? 64'(cur_row.val[match_j]) : '0;
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end else if (k_r == 2'd3) begin
            status_r    <= STATUS_FAIL;
            rv_r        <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FREE: begin
          if (pf) begin
            status_r    <= STATUS_OK;
            rv_r        <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end else if (k_r[1]) begin
            k_r     <= '0;
            state_r <= S_MV_RD;
          end else begin
            k_r <= 2'd2;
          end
        end
        S_MV_RD: state_r <= S_MV_CHK;
        S_MV_CHK: begin
          if (af) begin
            state_r <= S_MV_WB;
          end else if (i_r == IW'(S - 1)) begin
            i_r <= '0;
            if (k_r != 2'd3) begin
              k_r     <= k_r + 1'b1;
              state_r <= S_MV_RD;
            end else if (enable_r) begin
              k_r     <= 2'd2;
              state_r <= S_UP_RDF;
            end else begin
              status_r    <= STATUS_FAIL;
              rv_r        <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_RESULT;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MV_RD;
          end
        end
        S_UP_RDF: state_r <= S_UP_RDS;
        S_UP_RDS: begin
          upf_r   <= rd_top;
          state_r <= S_UP_CHK;
        end
        S_UP_CHK: begin
          if (pf) begin
            state_r <= S_UP_WB;
          end else if (i_r == IW'(S - 1)) begin
            i_r <= '0;
            if (k_r == 2'd2) begin
              k_r     <= 2'd3;
              state_r <= S_UP_RDF;
            end else begin
              status_r    <= STATUS_FAIL;
              rv_r        <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_RESULT;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_UP_RDF;
          end
        end
        S_MV_WB, S_UP_WB: begin
          status_r    <= STATUS_OK;
          rv_r        <= '0;
          out_valid_r <= 1'b1;
          state_r     <= S_RESULT;
        end
        S_RESULT: begin
          // Hold the beat until the receiver takes it.
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rv_r;

endmodule

/* src/lvh_checker.sv */
// Port-level checker for the two-level hash table, bound to the top level.
`include "assert_macros.svh"

module lvh_checker
  import lvh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [63:0] out_read_value
);

  // A stalled result beat holds.
  `LVH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_read_value))
  // One command in flight: busy right after a beat is taken.
  `LVH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // No input taken while a result waits.
  `LVH_ASSERT_IMPL(a_no_accept_with_result, clk, rst_n, out_valid, in_stall)
  // Failed commands return zero data.
  `LVH_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_status == STATUS_FAIL, out_read_value == 64'd0)

endmodule

bind two_level_cuckoo_hash_table lvh_checker u_lvh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_value (out_read_value)
);
